// ===== design/dpq_pkg.sv =====
// Package for the double-ended priority queue unit.
// Sizes, item and result structs, action/status codes and the cell control struct.
// No dependencies.
package dpq_pkg;

  // Queue depth and derived widths
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned POS_W    = $clog2(CAPACITY);
  localparam int unsigned OCC_W    = $clog2(CAPACITY + 1);
  localparam int unsigned ID_W     = 20;
  localparam int unsigned PRIO_W   = 24;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REM_HI = 2'd1,
    ACT_REM_LO = 2'd2
  } dpq_action_e;

  typedef enum logic [1:0] {
    ST_REMOVED = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2
  } dpq_status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SEARCH = 2'd1,
    S_REMOVE = 2'd2
  } dpq_state_e;

  // Input item
  typedef struct packed {
    logic [1:0]        action;
    logic [ID_W-1:0]   client_id;
    logic [PRIO_W-1:0] priority_req;
  } dpq_req_t;

  // Result item
  typedef struct packed {
    logic [ID_W-1:0] served_id;
    logic [1:0]      status;
  } dpq_res_t;

  // One stored pair
  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
  } dpq_entry_t;

  // Best-so-far candidate moving down the chain
  typedef struct packed {
    logic              valid;
    logic [PRIO_W-1:0] prio;
    logic [ID_W-1:0]   id;
    logic [POS_W-1:0]  pos;
  } dpq_cand_t;

  // Control broadcast from the controller to every cell
  typedef struct packed {
    logic             find_max;
    logic             ins_en;
    logic             shift_en;
    logic [OCC_W-1:0] occ;
    logic [POS_W-1:0] rm_pos;
  } dpq_cell_ctrl_t;

endpackage

// ===== design/dpq_cell.sv =====
// One queue cell: holds a pair in insertion order and refines the search candidate.
// Depends on dpq_pkg.
module dpq_cell (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  dpq_pkg::dpq_cell_ctrl_t ctrl_i,
  input  logic [dpq_pkg::POS_W-1:0] my_pos_i,
  input  dpq_pkg::dpq_entry_t     ins_entry_i,
  input  dpq_pkg::dpq_entry_t     nxt_entry_i,
  input  dpq_pkg::dpq_cand_t      cand_i,
  output dpq_pkg::dpq_entry_t     entry_o,
  output dpq_pkg::dpq_cand_t      cand_o
);

  dpq_pkg::dpq_entry_t entry_d, entry_q;
  dpq_pkg::dpq_cand_t  cand_d, cand_q;
  logic [dpq_pkg::OCC_W-1:0] pos_ext;
  logic occupied;
  logic take;

  assign pos_ext  = dpq_pkg::OCC_W'(my_pos_i);
  assign occupied = pos_ext < ctrl_i.occ;

  // Entry update: insert at the tail, or close the gap left by a removal
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins_en && (pos_ext == ctrl_i.occ)) begin
      entry_d = ins_entry_i;
    end else if (ctrl_i.shift_en && (my_pos_i >= ctrl_i.rm_pos)) begin
      entry_d = nxt_entry_i;
    end
  end

  // Candidate: later cells win ties, so the newest equal-priority pair is picked
  always_comb begin
    take = 1'b0;
    if (occupied) begin
      if (!cand_i.valid) begin
        take = 1'b1;
      end else if (ctrl_i.find_max) begin
        take = entry_q.prio >= cand_i.prio;
      end else begin
        take = entry_q.prio <= cand_i.prio;
      end
    end
    if (take) begin
      cand_d = '{valid: 1'b1, prio: entry_q.prio, id: entry_q.id, pos: my_pos_i};
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cand_q <= '0;
    end else begin
      cand_q <= cand_d;
    end
  end

  assign entry_o = entry_q;
  assign cand_o  = cand_q;

endmodule

// ===== design/dpq_ctrl.sv =====
// Controller: occupancy, search timing, cell control and the result register.
// Depends on dpq_pkg.
module dpq_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  dpq_pkg::dpq_req_t       req_i,
  input  dpq_pkg::dpq_cand_t      final_cand_i,
  output dpq_pkg::dpq_cell_ctrl_t cell_ctrl_o,
  output logic                    res_valid_o,
  output dpq_pkg::dpq_res_t       res_o
);

  dpq_pkg::dpq_state_e state_d, state_q;
  logic [dpq_pkg::OCC_W-1:0] occ_d, occ_q;
  logic [dpq_pkg::POS_W-1:0] cnt_d, cnt_q;
  logic find_max_d, find_max_q;
  logic res_valid_d, res_valid_q;
  dpq_pkg::dpq_res_t res_d, res_q;
  logic accept;
  logic is_remove;
  logic is_full;
  logic is_empty;

  assign accept    = start_i && (state_q == dpq_pkg::S_IDLE);
  assign is_remove = (req_i.action == dpq_pkg::ACT_REM_HI) ||
                     (req_i.action == dpq_pkg::ACT_REM_LO);
  assign is_full   = occ_q == dpq_pkg::OCC_W'(dpq_pkg::CAPACITY);
  assign is_empty  = occ_q == '0;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      dpq_pkg::S_IDLE: begin
        if (accept && is_remove && !is_empty) begin
          state_d = dpq_pkg::S_SEARCH;
        end
      end
      dpq_pkg::S_SEARCH: begin
        if (cnt_q == dpq_pkg::POS_W'(dpq_pkg::CAPACITY - 1)) begin
          state_d = dpq_pkg::S_REMOVE;
        end
      end
      dpq_pkg::S_REMOVE: state_d = dpq_pkg::S_IDLE;
      default:           state_d = dpq_pkg::S_IDLE;
    endcase
  end

  // Outputs toward the port and the cells
  always_comb begin
    busy_o               = state_q != dpq_pkg::S_IDLE;
    cell_ctrl_o.find_max = find_max_q;
    cell_ctrl_o.ins_en   = accept && (req_i.action == dpq_pkg::ACT_INSERT) && !is_full;
    cell_ctrl_o.shift_en = state_q == dpq_pkg::S_REMOVE;
    cell_ctrl_o.occ      = occ_q;
    cell_ctrl_o.rm_pos   = final_cand_i.pos;
  end

  // Occupancy, wavefront counter, mode and result
  always_comb begin
    occ_d       = occ_q;
    cnt_d       = '0;
    find_max_d  = find_max_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    if (state_q == dpq_pkg::S_SEARCH) begin
      cnt_d = cnt_q + 1'b1;
    end
    if (accept) begin
      case (req_i.action) inside
        dpq_pkg::ACT_INSERT: begin
          if (is_full) begin
            res_valid_d = 1'b1;
            res_d       = '{served_id: '0, status: dpq_pkg::ST_FULL};
          end else begin
            occ_d = occ_q + 1'b1;
          end
        end
        dpq_pkg::ACT_REM_HI, dpq_pkg::ACT_REM_LO: begin
          find_max_d = req_i.action == dpq_pkg::ACT_REM_HI;
          if (is_empty) begin
            res_valid_d = 1'b1;
            res_d       = '{served_id: '0, status: dpq_pkg::ST_EMPTY};
          end
        end
        default: ;
      endcase
    end
    if (state_q == dpq_pkg::S_REMOVE) begin
      occ_d       = occ_q - 1'b1;
      res_valid_d = 1'b1;
      res_d       = '{served_id: final_cand_i.id, status: dpq_pkg::ST_REMOVED};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dpq_pkg::S_IDLE;
      occ_q       <= '0;
      cnt_q       <= '0;
      find_max_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cnt_q       <= cnt_d;
      find_max_q  <= find_max_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== design/double_ended_priority_queue_unit.sv =====
// Top level of the double-ended priority queue: a chain of cells plus controller.
// Depends on dpq_pkg, dpq_cell and dpq_ctrl.
//
//   channel   handshake              payload          direction
//   request   start, busy            req_i  (dpq_req_t) in
//   result    res_valid_o (strobe)   res_o  (dpq_res_t) out
//
// Insert, removal from an empty queue, insert into a full queue and unused
// action codes leave busy low; any result strobes in the following cycle.
// A removal holds busy through S_SEARCH and S_REMOVE: the search candidate
// ripples one cell per cycle down the CAPACITY-cell chain, then S_REMOVE
// shifts the entries; the result strobes in the cycle in which busy falls.
// The result is held one cycle only; the receiver cannot stall it.
// Reset empties the queue; no clearing pass is needed.
module double_ended_priority_queue_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dpq_pkg::dpq_req_t req_i,
  output logic              res_valid_o,
  output dpq_pkg::dpq_res_t res_o
);

  dpq_pkg::dpq_cell_ctrl_t cell_ctrl;
  dpq_pkg::dpq_entry_t     ins_entry;
  dpq_pkg::dpq_entry_t     entry   [dpq_pkg::CAPACITY];
  dpq_pkg::dpq_entry_t     nxt     [dpq_pkg::CAPACITY];
  dpq_pkg::dpq_cand_t      cand_in [dpq_pkg::CAPACITY];
  dpq_pkg::dpq_cand_t      cand    [dpq_pkg::CAPACITY];

  assign ins_entry = '{prio: req_i.priority_req, id: req_i.client_id};

  // Controller
  dpq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .req_i        (req_i),
    .final_cand_i (cand[dpq_pkg::CAPACITY-1]),
    .cell_ctrl_o  (cell_ctrl),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

  // Cell chain, oldest entry in cell 0
  for (genvar g = 0; g < dpq_pkg::CAPACITY; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign cand_in[g] = '0;
    end else begin : g_link
      assign cand_in[g] = cand[g-1];
    end
    if (g == dpq_pkg::CAPACITY - 1) begin : g_tail
      assign nxt[g] = '0;
    end else begin : g_fwd
      assign nxt[g] = entry[g+1];
    end

    dpq_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .my_pos_i    (dpq_pkg::POS_W'(g)),
      .ins_entry_i (ins_entry),
      .nxt_entry_i (nxt[g]),
      .cand_i      (cand_in[g]),
      .entry_o     (entry[g]),
      .cand_o      (cand[g])
    );
  end

  // A removal request either strobes an empty result or starts a search
  a_remove_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && ((req_i.action == dpq_pkg::ACT_REM_HI) ||
                        (req_i.action == dpq_pkg::ACT_REM_LO)))
    |=> (busy || res_valid_o))
    else $error("removal neither searched nor answered");

  // An insert that fits gives no result
  a_insert_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (req_i.action == dpq_pkg::ACT_INSERT) &&
     (cell_ctrl.occ != dpq_pkg::OCC_W'(dpq_pkg::CAPACITY)))
    |=> !res_valid_o)
    else $error("successful insert produced a result");

  // The entry shift always has a valid candidate from the chain
  a_shift_cand: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.shift_en |-> cand[dpq_pkg::CAPACITY-1].valid)
    else $error("removal without a valid candidate");

  // Occupancy stays within the chain
  a_occ_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_ctrl.occ <= dpq_pkg::OCC_W'(dpq_pkg::CAPACITY))
    else $error("occupancy beyond capacity");

endmodule
